// ===== rtl/qi_pkg.sv =====
package qi_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int IN_W         = 16;
  localparam int C_SHIFT      = 2 * FRAC_BITS - 15;
  localparam int DOT_W        = 34;
  localparam int CORDIC_STEPS = 20;
  localparam int ANG_W        = 24;
  localparam int CD_W         = 34;
  localparam int ATAN_PRE     = 14;
  localparam int PROD_W       = 40;
  localparam int BW_W         = 50;
  localparam int V_W          = 52;
  localparam int MAG_W        = 30;
  localparam int SQ_W         = 64;
  localparam int N_W          = 32;
  localparam int QB           = FRAC_BITS + 2;
  localparam int QB_IW        = $clog2(QB);
  localparam int DV_W         = N_W + QB;
  localparam int RM_W         = QB + 1;
  localparam int SQ1_STEPS    = 16;
  localparam int SQ2_STEPS    = 31;
  localparam int NORM_STEPS   = 6;

  localparam logic [16:0] K_ONE = 17'd32768;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 24'sd3294199;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 24'sd1647099;
  localparam logic signed [CD_W-1:0]  CORDIC_START = 34'sd652032874;

  localparam logic CD_VEC = 1'b1;
  localparam logic CD_ROT = 1'b0;

  localparam logic [1:0] FLT_OK   = 2'd0;
  localparam logic [1:0] FLT_ZERO = 2'd1;
  localparam logic [1:0] FLT_SINE = 2'd2;

  typedef struct packed {
    logic                       func;
    logic [3:0][IN_W-1:0]       a;
    logic [3:0][IN_W-1:0]       b;
    logic [16:0]                k;
    logic [16:0]                cabs;
    logic                       dpos;
    logic                       cneg;
    logic                       szero;
    logic [3:0]                 vneg;
    logic                       zero;
    logic [3:0][MAG_W-1:0]      mg;
  } item_t;

  typedef struct packed {
    logic [SQ_W-1:0] q;
    logic [SQ_W-1:0] r;
  } sq_t;

  typedef struct packed {
    logic signed [CD_W-1:0]  x;
    logic signed [CD_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cd_t;

  typedef struct packed {
    logic [3:0][V_W-1:0] mag;
    logic [V_W-1:0]      m;
  } nm_t;

  typedef struct packed {
    logic [3:0][DV_W-1:0] rem;
    logic [3:0][QB-1:0]   quo;
    logic [N_W-1:0]       n;
  } dv_t;

  function automatic logic signed [ANG_W-1:0] atan_val(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      5'd0:    v = 24'sd823550;
      5'd1:    v = 24'sd486170;
      5'd2:    v = 24'sd256879;
      5'd3:    v = 24'sd130396;
      5'd4:    v = 24'sd65451;
      5'd5:    v = 24'sd32757;
      5'd6:    v = 24'sd16383;
      5'd7:    v = 24'sd8192;
      5'd8:    v = 24'sd4096;
      5'd9:    v = 24'sd2048;
      5'd10:   v = 24'sd1024;
      5'd11:   v = 24'sd512;
      5'd12:   v = 24'sd256;
      5'd13:   v = 24'sd128;
      5'd14:   v = 24'sd64;
      5'd15:   v = 24'sd32;
      5'd16:   v = 24'sd16;
      5'd17:   v = 24'sd8;
      5'd18:   v = 24'sd4;
      5'd19:   v = 24'sd2;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/qi_sqrt_cell.sv =====
module qi_sqrt_cell import qi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [5:0] bitpos,
  input  logic       in_vld,
  input  item_t      in_item,
  input  sq_t        in_sq,
  output logic       out_vld,
  output item_t      out_item,
  output sq_t        out_sq
);

  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] t;
  sq_t             sq_next;

  always_comb begin
    bitv = SQ_W'(1) << bitpos;
    t    = in_sq.r + bitv;
    if (in_sq.q >= t) begin
      sq_next.q = in_sq.q - t;
      sq_next.r = (in_sq.r >> 1) + bitv;
    end else begin
      sq_next.q = in_sq.q;
      sq_next.r = in_sq.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= in_item;
      out_sq   <= sq_next;
    end
  end

endmodule

// ===== rtl/qi_cordic_cell.sv =====
module qi_cordic_cell import qi_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          mode,
  input  logic [4:0]    step,
  input  logic          in_vld,
  input  item_t         in_item,
  input  cd_t [1:0]     in_cd,
  output logic          out_vld,
  output item_t         out_item,
  output cd_t [1:0]     out_cd
);

  cd_t [1:0]               cd_next;
  logic signed [CD_W-1:0]  xs [2];
  logic signed [CD_W-1:0]  ys [2];
  logic signed [ANG_W-1:0] da;
  logic                    neg [2];

  always_comb begin
    da = atan_val(step);
    for (int l = 0; l < 2; l++) begin
      xs[l] = $signed(in_cd[l].x) >>> step;
      ys[l] = $signed(in_cd[l].y) >>> step;
      // vectoring drives y to zero, rotation drives z to zero
      neg[l] = (mode == CD_VEC) ? ($signed(in_cd[l].y) > 0) : ($signed(in_cd[l].z) < 0);
      if (neg[l]) begin
        cd_next[l].x = in_cd[l].x + ys[l];
        cd_next[l].y = in_cd[l].y - xs[l];
        cd_next[l].z = in_cd[l].z + da;
      end else begin
        cd_next[l].x = in_cd[l].x - ys[l];
        cd_next[l].y = in_cd[l].y + xs[l];
        cd_next[l].z = in_cd[l].z - da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= in_item;
      out_cd   <= cd_next;
    end
  end

endmodule

// ===== rtl/qi_norm_cell.sv =====
module qi_norm_cell import qi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [5:0] amt,
  input  logic       in_vld,
  input  item_t      in_item,
  input  nm_t        in_nm,
  output logic       out_vld,
  output item_t      out_item,
  output nm_t        out_nm
);

  nm_t nm_next;

  always_comb begin
    nm_next = in_nm;
    if ((in_nm.m >> (7'(V_W) - 7'(amt))) == '0) begin
      nm_next.m = in_nm.m << amt;
      for (int l = 0; l < 4; l++) begin
        nm_next.mag[l] = in_nm.mag[l] << amt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= in_item;
      out_nm   <= nm_next;
    end
  end

endmodule

// ===== rtl/qi_div_cell.sv =====
module qi_div_cell import qi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [QB_IW-1:0] qbit,
  input  logic             in_vld,
  input  item_t            in_item,
  input  dv_t              in_dv,
  output logic             out_vld,
  output item_t            out_item,
  output dv_t              out_dv
);

  dv_t             dv_next;
  logic [DV_W-1:0] d;

  always_comb begin
    dv_next = in_dv;
    d       = DV_W'(in_dv.n) << qbit;
    for (int l = 0; l < 4; l++) begin
      if (in_dv.rem[l] >= d) begin
        dv_next.rem[l]       = in_dv.rem[l] - d;
        dv_next.quo[l][qbit] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= in_item;
      out_dv   <= dv_next;
    end
  end

endmodule

// ===== rtl/quaternion_interpolation.sv =====
// Quaternion blend, normalized linear (tuser 0) or spherical (tuser 1).
// Input channel s_*: one word per quaternion pair plus weight; tuser
// selects the mode. Output channel m_*: one word per input word, in order,
// with the unit-length result in tdata and the fault code in tuser
// (0 ok, 1 zero norm, 2 spherical sine zero, linear result given).
// Pipeline: input, product, dot, square, 16 square-root cells, CORDIC
// setup, 20 vectoring cells, angle, angle products, sine setup, 20
// rotation cells, weights, blend products, blend sum, magnitude, two max
// levels, 6 normalize cells, square, sum, 31 square-root cells, divide
// setup, 16 divider cells, output register: 127 registers in all. One
// word is taken every cycle while the output is not stalled; every
// stage holds one word, so a new word enters before earlier ones leave.
// All stages advance together while the output register is empty or
// being taken; when the receiver stalls, the whole pipe and s_tready hold.
// Reset clears every stage valid flag; payload is not reset.
module quaternion_interpolation import qi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // q0_w, q0_i, q0_j, q0_k, q1_w, q1_i, q1_j, q1_k, weight
  input  logic [143:0] s_tdata,
  // func
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // r_w, r_i, r_j, r_k
  output logic [63:0]  m_tdata,
  // fault
  output logic [1:0]   m_tuser
);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---- stage 0: capture
  item_t      it_in, it0;
  logic       vld0;
  logic [15:0] kin;

  always_comb begin
    it_in      = '0;
    it_in.func = s_tuser[0];
    for (int i = 0; i < 4; i++) begin
      it_in.a[i] = s_tdata[16*i +: 16];
      it_in.b[i] = s_tdata[64+16*i +: 16];
    end
    kin     = s_tdata[143:128];
    it_in.k = ({1'b0, kin} > K_ONE) ? K_ONE : {1'b0, kin};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it0 <= it_in;
    end
  end

  // ---- stage 1: products
  item_t             it1;
  logic              vld1;
  logic signed [31:0] prod1 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= vld0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it1 <= it0;
      for (int i = 0; i < 4; i++) begin
        prod1[i] <= $signed(it0.a[i]) * $signed(it0.b[i]);
      end
    end
  end

  // ---- stage 2: dot product, cosine in Q1.15
  item_t              it2, it1m;
  logic               vld2;
  logic signed [DOT_W-1:0] dot, csh;
  logic signed [16:0] c_sat, c2;

  always_comb begin
    dot = '0;
    for (int i = 0; i < 4; i++) begin
      dot = dot + DOT_W'(prod1[i]);
    end
    csh = dot >>> C_SHIFT;
    if (csh > 34'sd32768) begin
      c_sat = 17'sd32768;
    end else if (csh < -34'sd32768) begin
      c_sat = -17'sd32768;
    end else begin
      c_sat = 17'(csh);
    end
    it1m      = it1;
    it1m.dpos = dot > 0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it2 <= it1m;
      c2  <= c_sat;
    end
  end

  // ---- stage 3: 1 - c^2
  item_t              it2m;
  sq_t                sq3_in;
  logic signed [33:0] cc;

  always_comb begin
    cc          = 34'(c2) * 34'(c2);
    sq3_in.q    = (SQ_W'(1) << 30) - SQ_W'(unsigned'(cc));
    sq3_in.r    = '0;
    it2m        = it2;
    it2m.cneg   = c2 < 0;
    it2m.cabs   = (c2 < 0) ? 17'(-c2) : 17'(c2);
  end

  logic  sq1_vld [SQ1_STEPS+1];
  item_t sq1_it  [SQ1_STEPS+1];
  sq_t   sq1_sq  [SQ1_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq1_vld[0] <= 1'b0;
    end else if (en) begin
      sq1_vld[0] <= vld2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq1_it[0] <= it2m;
      sq1_sq[0] <= sq3_in;
    end
  end

  for (genvar g = 0; g < SQ1_STEPS; g++) begin : g_sq1
    qi_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .bitpos  (6'(30 - 2*g)),
      .in_vld  (sq1_vld[g]),
      .in_item (sq1_it[g]),
      .in_sq   (sq1_sq[g]),
      .out_vld (sq1_vld[g+1]),
      .out_item(sq1_it[g+1]),
      .out_sq  (sq1_sq[g+1])
    );
  end

  // ---- stage 4: vectoring setup, atan2(s, |c|)
  logic      s_val;
  item_t     it3m;
  cd_t [1:0] cdv_in;
  logic [15:0] sine;

  always_comb begin
    sine       = sq1_sq[SQ1_STEPS].r[15:0];
    s_val      = sine == '0;
    it3m       = sq1_it[SQ1_STEPS];
    it3m.szero = s_val;
    cdv_in     = '0;
    cdv_in[0].x = CD_W'({it3m.cabs, ATAN_PRE'(0)});
    cdv_in[0].y = CD_W'({sine, ATAN_PRE'(0)});
  end

  logic      cv_vld [CORDIC_STEPS+1];
  item_t     cv_it  [CORDIC_STEPS+1];
  cd_t [1:0] cv_cd  [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_vld[0] <= 1'b0;
    end else if (en) begin
      cv_vld[0] <= sq1_vld[SQ1_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cv_it[0] <= it3m;
      cv_cd[0] <= cdv_in;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    qi_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .mode    (CD_VEC),
      .step    (5'(g)),
      .in_vld  (cv_vld[g]),
      .in_item (cv_it[g]),
      .in_cd   (cv_cd[g]),
      .out_vld (cv_vld[g+1]),
      .out_item(cv_it[g+1]),
      .out_cd  (cv_cd[g+1])
    );
  end

  // ---- stage 5: angle
  item_t                   it5;
  logic                    vld5;
  logic signed [ANG_W-1:0] zc, ang_c;
  logic [ANG_W-1:0]        ang5;

  always_comb begin
    zc = cv_cd[CORDIC_STEPS][0].z;
    if (zc < 0) begin
      zc = '0;
    end else if (zc > ANG_HALF_PI) begin
      zc = ANG_HALF_PI;
    end
    ang_c = cv_it[CORDIC_STEPS].cneg ? (ANG_PI - zc) : zc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
    end else if (en) begin
      vld5 <= cv_vld[CORDIC_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it5  <= cv_it[CORDIC_STEPS];
      ang5 <= unsigned'(ang_c);
    end
  end

  // ---- stage 6: angle times weights
  item_t             it6;
  logic              vld6;
  logic [PROD_W-1:0] pt0, pt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld6 <= 1'b0;
    end else if (en) begin
      vld6 <= vld5;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it6 <= it5;
      pt0 <= PROD_W'(K_ONE - it5.k) * PROD_W'(ang5);
      pt1 <= PROD_W'(it5.k) * PROD_W'(ang5);
    end
  end

  // ---- stage 7: sine setup, fold into [0, PI/2]
  logic [PROD_W-1:0]       th [2];
  logic signed [ANG_W-1:0] thz [2];
  cd_t [1:0]               cdr_in;

  always_comb begin
    th[0] = pt0 >> 15;
    th[1] = pt1 >> 15;
    cdr_in = '0;
    for (int l = 0; l < 2; l++) begin
      if (th[l] > PROD_W'(unsigned'(ANG_PI))) begin
        th[l] = PROD_W'(unsigned'(ANG_PI));
      end
      thz[l] = ANG_W'(th[l]);
      if (thz[l] > ANG_HALF_PI) begin
        thz[l] = ANG_PI - thz[l];
      end
      cdr_in[l].x = CORDIC_START;
      cdr_in[l].y = '0;
      cdr_in[l].z = thz[l];
    end
  end

  logic      cr_vld [CORDIC_STEPS+1];
  item_t     cr_it  [CORDIC_STEPS+1];
  cd_t [1:0] cr_cd  [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_vld[0] <= 1'b0;
    end else if (en) begin
      cr_vld[0] <= vld6;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cr_it[0] <= it6;
      cr_cd[0] <= cdr_in;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    qi_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .mode    (CD_ROT),
      .step    (5'(g)),
      .in_vld  (cr_vld[g]),
      .in_item (cr_it[g]),
      .in_cd   (cr_cd[g]),
      .out_vld (cr_vld[g+1]),
      .out_item(cr_it[g+1]),
      .out_cd  (cr_cd[g+1])
    );
  end

  // ---- stage 8: blend weights
  item_t                  it8, itr;
  logic                   vld8;
  logic                   use_sph;
  logic signed [CD_W-1:0] w0_c, w1_c, w0, w1;

  always_comb begin
    itr     = cr_it[CORDIC_STEPS];
    use_sph = itr.func && !itr.szero;
    if (use_sph) begin
      w0_c = cr_cd[CORDIC_STEPS][0].y;
      w1_c = cr_cd[CORDIC_STEPS][1].y;
    end else begin
      w0_c = CD_W'(K_ONE - itr.k);
      w1_c = itr.dpos ? CD_W'(itr.k) : -CD_W'(itr.k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld8 <= 1'b0;
    end else if (en) begin
      vld8 <= cr_vld[CORDIC_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it8 <= itr;
      w0  <= w0_c;
      w1  <= w1_c;
    end
  end

  // ---- stage 9: blend products
  item_t                  it9;
  logic                   vld9;
  logic signed [BW_W-1:0] pa [4];
  logic signed [BW_W-1:0] pb [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld9 <= 1'b0;
    end else if (en) begin
      vld9 <= vld8;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it9 <= it8;
      for (int i = 0; i < 4; i++) begin
        pa[i] <= BW_W'($signed(it8.a[i])) * BW_W'(w0);
        pb[i] <= BW_W'($signed(it8.b[i])) * BW_W'(w1);
      end
    end
  end

  // ---- stage 10: blend sum
  item_t                 it10;
  logic                  vld10;
  logic signed [V_W-1:0] v10 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld10 <= 1'b0;
    end else if (en) begin
      vld10 <= vld9;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it10 <= it9;
      for (int i = 0; i < 4; i++) begin
        v10[i] <= V_W'(pa[i]) + V_W'(pb[i]);
      end
    end
  end

  // ---- stage 11: magnitudes
  item_t         it10m, it11;
  logic          vld11;
  logic [3:0][V_W-1:0] mag11;

  always_comb begin
    it10m = it10;
    for (int i = 0; i < 4; i++) begin
      it10m.vneg[i] = v10[i] < 0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld11 <= 1'b0;
    end else if (en) begin
      vld11 <= vld10;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it11 <= it10m;
      for (int i = 0; i < 4; i++) begin
        mag11[i] <= (v10[i] < 0) ? unsigned'(-v10[i]) : unsigned'(v10[i]);
      end
    end
  end

  // ---- stage 12: pairwise max
  item_t               it12;
  logic                vld12;
  logic [3:0][V_W-1:0] mag12;
  logic [V_W-1:0]      m01, m23;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld12 <= 1'b0;
    end else if (en) begin
      vld12 <= vld11;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it12  <= it11;
      mag12 <= mag11;
      m01   <= (mag11[0] > mag11[1]) ? mag11[0] : mag11[1];
      m23   <= (mag11[2] > mag11[3]) ? mag11[2] : mag11[3];
    end
  end

  // ---- stage 13: max, then normalize chain
  nm_t   nm_in;
  item_t it12m;

  always_comb begin
    nm_in.mag  = mag12;
    nm_in.m    = (m01 > m23) ? m01 : m23;
    it12m      = it12;
    it12m.zero = nm_in.m == '0;
  end

  logic  nm_vld [NORM_STEPS+1];
  item_t nm_it  [NORM_STEPS+1];
  nm_t   nm_nm  [NORM_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_vld[0] <= 1'b0;
    end else if (en) begin
      nm_vld[0] <= vld12;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nm_it[0] <= it12m;
      nm_nm[0] <= nm_in;
    end
  end

  for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
    qi_norm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .amt     (6'(32 >> g)),
      .in_vld  (nm_vld[g]),
      .in_item (nm_it[g]),
      .in_nm   (nm_nm[g]),
      .out_vld (nm_vld[g+1]),
      .out_item(nm_it[g+1]),
      .out_nm  (nm_nm[g+1])
    );
  end

  // ---- stage 14: squares of the leading 30 bits
  item_t            it13m, it14;
  logic             vld14;
  logic [2*MAG_W-1:0] sqv [4];

  always_comb begin
    it13m = nm_it[NORM_STEPS];
    for (int i = 0; i < 4; i++) begin
      it13m.mg[i] = nm_nm[NORM_STEPS].mag[i][V_W-1 -: MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld14 <= 1'b0;
    end else if (en) begin
      vld14 <= nm_vld[NORM_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      it14 <= it13m;
      for (int i = 0; i < 4; i++) begin
        sqv[i] <= (2*MAG_W)'(it13m.mg[i]) * (2*MAG_W)'(it13m.mg[i]);
      end
    end
  end

  // ---- stage 15: sum of squares, then root chain
  sq_t sq15_in;

  always_comb begin
    sq15_in.q = '0;
    for (int i = 0; i < 4; i++) begin
      sq15_in.q = sq15_in.q + SQ_W'(sqv[i]);
    end
    sq15_in.r = '0;
  end

  logic  sq2_vld [SQ2_STEPS+1];
  item_t sq2_it  [SQ2_STEPS+1];
  sq_t   sq2_sq  [SQ2_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq2_vld[0] <= 1'b0;
    end else if (en) begin
      sq2_vld[0] <= vld14;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq2_it[0] <= it14;
      sq2_sq[0] <= sq15_in;
    end
  end

  for (genvar g = 0; g < SQ2_STEPS; g++) begin : g_sq2
    qi_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .bitpos  (6'(60 - 2*g)),
      .in_vld  (sq2_vld[g]),
      .in_item (sq2_it[g]),
      .in_sq   (sq2_sq[g]),
      .out_vld (sq2_vld[g+1]),
      .out_item(sq2_it[g+1]),
      .out_sq  (sq2_sq[g+1])
    );
  end

  // ---- stage 16: divide setup, numerator rounds half up
  dv_t           dv_in;
  logic [N_W-1:0] nrm;

  always_comb begin
    nrm      = sq2_sq[SQ2_STEPS].r[N_W-1:0];
    dv_in.n  = nrm;
    dv_in.quo = '0;
    for (int i = 0; i < 4; i++) begin
      dv_in.rem[i] = DV_W'({sq2_it[SQ2_STEPS].mg[i], FRAC_BITS'(0)}) + DV_W'(nrm >> 1);
    end
  end

  logic  dv_vld [QB+1];
  item_t dv_it  [QB+1];
  dv_t   dv_dv  [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq2_vld[SQ2_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dv_it[0] <= sq2_it[SQ2_STEPS];
      dv_dv[0] <= dv_in;
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    qi_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .qbit    (QB_IW'(QB - 1 - g)),
      .in_vld  (dv_vld[g]),
      .in_item (dv_it[g]),
      .in_dv   (dv_dv[g]),
      .out_vld (dv_vld[g+1]),
      .out_item(dv_it[g+1]),
      .out_dv  (dv_dv[g+1])
    );
  end

  // ---- output register: sign, saturation, fault
  item_t             ito;
  logic [RM_W-1:0]   rm [4];
  logic [63:0]       tdata_next;
  logic [1:0]        fault_next;

  always_comb begin
    ito = dv_it[QB];
    for (int i = 0; i < 4; i++) begin
      rm[i] = {1'b0, dv_dv[QB].quo[i]};
      if (ito.vneg[i]) begin
        if (rm[i] > RM_W'(32768)) begin
          rm[i] = RM_W'(32768);
        end
        tdata_next[16*i +: 16] = 16'(RM_W'(0) - rm[i]);
      end else begin
        if (rm[i] > RM_W'(32767)) begin
          rm[i] = RM_W'(32767);
        end
        tdata_next[16*i +: 16] = 16'(rm[i]);
      end
    end
    if (ito.zero) begin
      tdata_next = '0;
      fault_next = FLT_ZERO;
    end else if (ito.func && ito.szero) begin
      fault_next = FLT_SINE;
    end else begin
      fault_next = FLT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_vld[QB];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= tdata_next;
      m_tuser <= fault_next;
    end
  end

`ifndef ASSERT_OFF
  a_zero_norm_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == FLT_ZERO |-> m_tdata == '0)
    else $error("zero-norm word carries nonzero data");

  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == FLT_OK || m_tuser == FLT_ZERO || m_tuser == FLT_SINE))
    else $error("undefined fault code");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && !$past(s_tready))
    else $error("pipe moved while output stalled");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top import qi_pkg::*; ();

  typedef struct {
    logic             mode;
    logic [15:0]      q0 [4];
    logic [15:0]      q1 [4];
    logic [15:0]      k;
  } pair_t;

  typedef struct {
    logic [15:0] c [4];
    logic [1:0]  flt;
  } blend_t;

  typedef struct {
    pair_t  p;
    logic   known;   // expected result typed in
    blend_t res;
  } row_t;

  localparam int N_RANDOM = 540;
  localparam longint TAN_TAB [20] = '{823550, 486170, 256879, 130396, 65451, 32757,
    16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;

  blend_t expected_q [$];
  int     errors = 0;
  bit     quiet = 0;     // no idling near the end
  bit     hold_long = 0;
  bit     sent_all = 0;

  quaternion_interpolation uut (.*);

  always #5 clk = ~clk;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root64(longint unsigned q);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > q) b >>= 2;
    while (b != 0) begin
      if (q >= r + b) begin
        q -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint sine_q30(longint th);
    longint x = 652032874, y = 0, z, xs, ys;
    if (th < 0) th = 0;
    if (th > 3294199) th = 3294199;
    if (th > 1647099) th = 3294199 - th;
    z = th;
    for (int i = 0; i < 20; i++) begin
      xs = shr_floor(x, i); ys = shr_floor(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= TAN_TAB[i];
      end else begin
        x += ys; y -= xs; z += TAN_TAB[i];
      end
    end
    return y;
  endfunction

  function automatic longint arc_angle(longint xc, longint ys0);
    longint x = xc * 16384, y = ys0 * 16384, z = 0, xs, ys;
    for (int i = 0; i < 20; i++) begin
      xs = shr_floor(x, i); ys = shr_floor(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += TAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= TAN_TAB[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 1647099) z = 1647099;
    return z;
  endfunction

  function automatic bit unit_scale(longint v [4], output logic [15:0] r [4]);
    longint unsigned mag [4], m = 0, q = 0, n, rm;
    int down = 0, up = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = v[i] < 0 ? longint'(-v[i]) : v[i];
      if (mag[i] > m) m = mag[i];
      r[i] = '0;
    end
    if (m == 0) return 0;
    while (m >= (64'd1 << 30)) begin m >>= 1; down++; end
    while (m < (64'd1 << 29)) begin m <<= 1; up++; end
    for (int i = 0; i < 4; i++) begin
      mag[i] = (mag[i] >> down) << up;
      q += mag[i] * mag[i];
    end
    n = root64(q);
    for (int i = 0; i < 4; i++) begin
      rm = ((mag[i] << FRAC_BITS) + n / 2) / n;
      if (v[i] < 0) begin
        if (rm > 32768) rm = 32768;
        r[i] = 16'(-longint'(rm));
      end else begin
        if (rm > 32767) rm = 32767;
        r[i] = 16'(rm);
      end
    end
    return 1;
  endfunction

  function automatic blend_t interpolate(pair_t p);
    blend_t o;
    longint a [4], b [4], v [4], dot = 0, k, c, s, ang, w0, w1, k0, k1;
    bit done = 0;
    o.flt = FLT_OK;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(p.q0[i]));
      b[i] = longint'($signed(p.q1[i]));
      dot += a[i] * b[i];
    end
    k = p.k;
    if (k > 32768) k = 32768;
    if (p.mode) begin
      c = shr_floor(dot, C_SHIFT);
      if (c > 32768) c = 32768;
      if (c < -32768) c = -32768;
      s = root64((64'd1 << 30) - c * c);
      if (s == 0) begin
        o.flt = FLT_SINE;
      end else begin
        ang = arc_angle(c < 0 ? -c : c, s);
        if (c < 0) ang = 3294199 - ang;
        w0 = sine_q30(((32768 - k) * ang) >>> 15);
        w1 = sine_q30((k * ang) >>> 15);
        for (int i = 0; i < 4; i++) v[i] = a[i] * w0 + b[i] * w1;
        if (!unit_scale(v, o.c)) o.flt = FLT_ZERO;
        done = 1;
      end
    end
    if (!done) begin
      k0 = 32768 - k;
      k1 = dot > 0 ? k : -k;
      for (int i = 0; i < 4; i++) v[i] = a[i] * k0 + b[i] * k1;
      if (!unit_scale(v, o.c)) o.flt = FLT_ZERO;
    end
    return o;
  endfunction

  function automatic pair_t mk(logic md, int w0, int i0, int j0, int k0,
                               int w1, int i1, int j1, int k1, int wt);
    pair_t p;
    p.mode = md;
    p.q0 = '{16'(w0), 16'(i0), 16'(j0), 16'(k0)};
    p.q1 = '{16'(w1), 16'(i1), 16'(j1), 16'(k1)};
    p.k = 16'(wt);
    return p;
  endfunction

  function automatic blend_t res(int w, int i, int j, int k, logic [1:0] f);
    blend_t r;
    r.c = '{16'(w), 16'(i), 16'(j), 16'(k)};
    r.flt = f;
    return r;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int sh;
    p.mode = 1'($urandom_range(0, 1));
    sh = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      p.q0[i] = 16'($urandom);
      p.q1[i] = 16'($urandom);
      // mostly unit-ish values, sometimes full range
      if (sh != 0) begin
        p.q0[i] = 16'($signed(p.q0[i]) >>> sh);
        p.q1[i] = 16'($signed(p.q1[i]) >>> sh);
      end
    end
    case ($urandom_range(0, 9))
      0: p.q1 = p.q0;                                  // parallel: sine zero
      1: for (int i = 0; i < 4; i++) p.q1[i] = -p.q0[i];
      2: p.k = 16'($urandom_range(32768, 65535));
      3: p.k = $urandom_range(0, 1) ? 16'd0 : 16'd32768;
      default: p.k = 16'($urandom_range(0, 32768));
    endcase
    if (p.k === 'x) p.k = 16'($urandom_range(0, 32768));
    return p;
  endfunction

  row_t rows [$];
  initial begin
    blend_t z;
    z = res(0, 0, 0, 0, FLT_ZERO);
    // zero inputs, both modes; spherical sees sine one, then zero norm
    rows.push_back('{mk(0, 0,0,0,0, 0,0,0,0, 16384), 1, z});
    rows.push_back('{mk(1, 0,0,0,0, 0,0,0,0, 16384), 1, z});
    // k = 0 gives q0 exactly
    rows.push_back('{mk(0, 16384,0,0,0, 0,16384,0,0, 0), 1, res(16384,0,0,0,FLT_OK)});
    // k = 1 and orthogonal: dot zero gives -k
    rows.push_back('{mk(0, 16384,0,0,0, 0,16384,0,0, 32768), 1,
                     res(0,-16384,0,0,FLT_OK)});
    // identical unit quaternions in spherical mode: sine zero, fell back
    rows.push_back('{mk(1, 16384,0,0,0, 16384,0,0,0, 12000), 1,
                     res(16384,0,0,0,FLT_SINE)});
    // opposite: negative dot flips q1, so the blend stays on q0
    rows.push_back('{mk(0, 16384,0,0,0, -16384,0,0,0, 16384), 1,
                     res(16384,0,0,0,FLT_OK)});
    rows.push_back('{mk(1, 16384,0,0,0, -16384,0,0,0, 16384), 1,
                     res(16384,0,0,0,FLT_SINE)});
    // weight above one
    rows.push_back('{mk(0, 16384,0,0,0, 0,0,16384,0, 65535), 0, z});
    rows.push_back('{mk(1, 16384,0,0,0, 0,0,16384,0, 40000), 0, z});
    // field extremes, then assorted other pairs
    rows.push_back('{mk(0, -32768,-32768,-32768,-32768, 32767,32767,32767,32767, 65535), 0, z});
    rows.push_back('{mk(1, 32767,32767,32767,32767, -32768,-32768,-32768,-32768, 1), 0, z});
    rows.push_back('{mk(1, 32767,-32768,32767,-32768, 32767,-32768,32767,-32768, 32768), 0, z});
    rows.push_back('{mk(1, 16384,0,0,0, 11585,11585,0,0, 16384), 0, z});
    rows.push_back('{mk(1, 16384,0,0,0, -11585,11585,0,0, 8192), 0, z});
    rows.push_back('{mk(0, 1,0,0,0, 0,0,0,-1, 16384), 0, z});
    rows.push_back('{mk(1, 1,0,0,0, 0,1,0,0, 32767), 0, z});
    rows.push_back('{mk(1, 0,0,0,16384, 0,0,16384,0, 21845), 0, z});
  end

  task automatic offer(pair_t p);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= p.mode;
    s_tdata  <= {p.k, p.q1[3], p.q1[2], p.q1[1], p.q1[0],
                 p.q0[3], p.q0[2], p.q0[1], p.q0[0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // sender
  initial begin
    pair_t p;
    blend_t want;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[r]) begin
      want = interpolate(rows[r].p);
      if (rows[r].known) want = rows[r].res;
      expected_q.push_back(want);
      offer(rows[r].p);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 100) hold_long = 1;
      if (n == 450) quiet = 1;
      p = rand_pair();
      expected_q.push_back(interpolate(p));
      offer(p);
    end
    s_tvalid <= 1'b0;
    sent_all = 1;
  end

  // receiver ready
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        hold_long = 0;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 17);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    blend_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h/%0d", m_tdata, m_tuser);
        errors++;
      end else begin
        w = expected_q.pop_front();
        for (int i = 0; i < 4; i++)
          if (m_tdata[16*i +: 16] !== w.c[i]) begin
            $error("r_%s expected %0d actual %0d", i == 0 ? "w" : i == 1 ? "i" :
                   i == 2 ? "j" : "k", $signed(w.c[i]), $signed(m_tdata[16*i +: 16]));
            errors++;
          end
        if (m_tuser !== w.flt) begin
          $error("fault expected %0d actual %0d", w.flt, m_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (sent_all);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== quaternion_interpolation.f =====
rtl/qi_pkg.sv
rtl/qi_sqrt_cell.sv
rtl/qi_cordic_cell.sv
rtl/qi_norm_cell.sv
rtl/qi_div_cell.sv
rtl/quaternion_interpolation.sv
tb/tb_top.sv
